/* sv/blo_pkg.sv */
// ---------------------------------------------------------------------------
// blo_pkg
// Shared types and constants for the bounded ordered list.
// ---------------------------------------------------------------------------
package blo_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 10;

  // Fixed field widths of the stream words
  localparam int OP_W   = 3;
  localparam int POS_W  = 7;
  localparam int NV_W   = 10;
  localparam int RV_W   = 11;
  localparam int CNT_W  = 7;

  // Derived widths
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

  localparam logic [RV_W-1:0] EMPTY_VALUE = '1;

  typedef enum logic [OP_W-1:0] {
    OP_PEEK   = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_REMOVE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  // Command from controller to datapath
  typedef struct packed {
    logic exec;   // execute the accepted word and load the result register
  } ctrl_cmd_t;

endpackage

/* sv/blo_ctrl.sv */
// ---------------------------------------------------------------------------
// blo_ctrl
// Handshake controller: tracks the result register and issues execute.
// ---------------------------------------------------------------------------
module blo_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output blo_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic {
    RES_EMPTY,
    RES_FULL
  } state_t;

  state_t state;

  // Accept while the result register is free or being emptied
  assign s_tready = (state == RES_EMPTY) || m_tready;
  assign cmd.exec = s_tvalid && s_tready;
  assign m_tvalid = (state == RES_FULL);

  // Hold or release the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RES_EMPTY;
    end else begin
      case (state)
        RES_EMPTY: begin
          if (cmd.exec) state <= RES_FULL;
        end
        RES_FULL: begin
          if (m_tready && !cmd.exec) state <= RES_EMPTY;
        end
        default: state <= RES_EMPTY;
      endcase
    end
  end

endmodule

/* sv/blo_datapath.sv */
// ---------------------------------------------------------------------------
// blo_datapath
// Row of entry cells with shift paths, list length and result register.
// ---------------------------------------------------------------------------
module blo_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  blo_pkg::ctrl_cmd_t            cmd,
  input  logic [blo_pkg::OP_W-1:0]      operation,
  input  logic [blo_pkg::POS_W-1:0]     position,
  input  logic                          new_kind,
  input  logic [blo_pkg::NV_W-1:0]      new_value,
  output logic                          ok,
  output logic                          read_kind,
  output logic [blo_pkg::RV_W-1:0]      read_value,
  output logic [blo_pkg::CNT_W-1:0]     count
);

  logic                       kind_q  [blo_pkg::CAPACITY];
  logic [blo_pkg::RV_W-1:0]   value_q [blo_pkg::CAPACITY];
  logic                       kind_next  [blo_pkg::CAPACITY];
  logic [blo_pkg::RV_W-1:0]   value_next [blo_pkg::CAPACITY];
  logic                       kind_up  [blo_pkg::CAPACITY];
  logic [blo_pkg::RV_W-1:0]   value_up [blo_pkg::CAPACITY];
  logic                       kind_dn  [blo_pkg::CAPACITY];
  logic [blo_pkg::RV_W-1:0]   value_dn [blo_pkg::CAPACITY];

  logic [blo_pkg::LEN_W-1:0]  len;
  logic [blo_pkg::LEN_W-1:0]  len_next;
  logic [blo_pkg::CMP_W-1:0]  pos_e;
  logic [blo_pkg::CMP_W-1:0]  len_e;
  logic [blo_pkg::CMP_W-1:0]  cap_e;
  logic [blo_pkg::RV_W-1:0]   stored_value;
  blo_pkg::op_t               op;

  logic ok_next;
  logic rk_next;
  logic [blo_pkg::RV_W-1:0]   rv_next;
  logic peek_hit, append_ok, insert_ok, remove_ok, do_clear;

  assign op    = blo_pkg::op_t'(operation);
  assign pos_e = blo_pkg::CMP_W'(position);
  assign len_e = blo_pkg::CMP_W'(len);
  assign cap_e = blo_pkg::CMP_W'(blo_pkg::CAPACITY);

  // Mask the new value to the stored value width
  always_comb begin
    stored_value = '0;
    stored_value[blo_pkg::VALUE_BITS-1:0] = new_value[blo_pkg::VALUE_BITS-1:0];
  end

  // Decode the operation and its range checks
  always_comb begin
    peek_hit  = 1'b0;
    append_ok = 1'b0;
    insert_ok = 1'b0;
    remove_ok = 1'b0;
    do_clear  = 1'b0;
    case (op)
      blo_pkg::OP_PEEK:   peek_hit  = (pos_e < len_e) && (pos_e < cap_e);
      blo_pkg::OP_APPEND: append_ok = (len_e < cap_e);
      blo_pkg::OP_INSERT: insert_ok = (pos_e <= len_e) && (pos_e < cap_e);
      blo_pkg::OP_REMOVE: remove_ok = (pos_e < len_e);
      blo_pkg::OP_CLEAR:  do_clear  = 1'b1;
      default: ;
    endcase
  end

  // Neighbour taps for the shift paths
  always_comb begin
    for (int i = 0; i < blo_pkg::CAPACITY; i++) begin
      if (i + 1 < blo_pkg::CAPACITY) begin
        kind_up[i]  = kind_q[i+1];
        value_up[i] = value_q[i+1];
      end else begin
        kind_up[i]  = 1'b0;
        value_up[i] = blo_pkg::EMPTY_VALUE;
      end
      if (i > 0) begin
        kind_dn[i]  = kind_q[i-1];
        value_dn[i] = value_q[i-1];
      end else begin
        kind_dn[i]  = 1'b0;
        value_dn[i] = blo_pkg::EMPTY_VALUE;
      end
    end
  end

  // Per-cell next value: hold, load, shift down, shift up or empty
  always_comb begin
    for (int i = 0; i < blo_pkg::CAPACITY; i++) begin
      kind_next[i]  = kind_q[i];
      value_next[i] = value_q[i];
      if (do_clear) begin
        kind_next[i]  = 1'b0;
        value_next[i] = blo_pkg::EMPTY_VALUE;
      end else if (append_ok) begin
        if (blo_pkg::CMP_W'(i) == len_e) begin
          kind_next[i]  = new_kind;
          value_next[i] = stored_value;
        end
      end else if (insert_ok) begin
        if (blo_pkg::CMP_W'(i) == pos_e) begin
          kind_next[i]  = new_kind;
          value_next[i] = stored_value;
        end else if (blo_pkg::CMP_W'(i) > pos_e) begin
          kind_next[i]  = kind_dn[i];
          value_next[i] = value_dn[i];
        end
      end else if (remove_ok) begin
        if (blo_pkg::CMP_W'(i) >= pos_e) begin
          kind_next[i]  = kind_up[i];
          value_next[i] = value_up[i];
        end
      end
    end
  end

  // Length update
  always_comb begin
    len_next = len;
    if (do_clear) begin
      len_next = '0;
    end else if (append_ok) begin
      len_next = len + 1'b1;
    end else if (insert_ok) begin
      if (len_e < cap_e) len_next = len + 1'b1;
    end else if (remove_ok) begin
      len_next = len - 1'b1;
    end
  end

  // Result fields
  always_comb begin
    ok_next = peek_hit || append_ok || insert_ok || remove_ok || do_clear;
    rk_next = 1'b0;
    rv_next = blo_pkg::EMPTY_VALUE;
    if (peek_hit) begin
      rk_next = kind_q[position[blo_pkg::IDX_W-1:0]];
      rv_next = value_q[position[blo_pkg::IDX_W-1:0]];
    end
  end

  // Update cells and length on execute
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < blo_pkg::CAPACITY; i++) begin
        kind_q[i]  <= 1'b0;
        value_q[i] <= blo_pkg::EMPTY_VALUE;
      end
      len <= '0;
    end else if (cmd.exec) begin
      for (int i = 0; i < blo_pkg::CAPACITY; i++) begin
        kind_q[i]  <= kind_next[i];
        value_q[i] <= value_next[i];
      end
      len <= len_next;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok         <= ok_next;
      read_kind  <= rk_next;
      read_value <= rv_next;
      count      <= blo_pkg::CNT_W'(len_next);
    end
  end

endmodule

/* sv/bounded_ordered_list.sv */
// A result word is registered and is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle while results are taken; every operation,
// shifts included, completes in a single update of the register cell row.
// Input is held off only while an unread result waits and m_tready is low.
// Reset (rst, synchronous): all cells empty (kind 0, value -1), length 0.
// ---------------------------------------------------------------------------
// bounded_ordered_list
// Ordered list of kind/value entries with peek, append, insert, remove, clear.
// ---------------------------------------------------------------------------
module bounded_ordered_list (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // position[6:0], new_value[16:7], zero pad
  input  logic [3:0]  s_tuser,   // operation[2:0], new_kind[3]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // read_value[10:0], count[17:11], zero pad
  output logic [1:0]  m_tuser    // ok[0], read_kind[1]
);

  blo_pkg::ctrl_cmd_t              cmd;
  logic                            ok;
  logic                            read_kind;
  logic [blo_pkg::RV_W-1:0]        read_value;
  logic [blo_pkg::CNT_W-1:0]       count;

  blo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  blo_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .operation  (s_tuser[2:0]),
    .position   (s_tdata[6:0]),
    .new_kind   (s_tuser[3]),
    .new_value  (s_tdata[16:7]),
    .ok         (ok),
    .read_kind  (read_kind),
    .read_value (read_value),
    .count      (count)
  );

  // Pack the result word
  assign m_tdata = {6'd0, count, read_value};
  assign m_tuser = {read_kind, ok};

endmodule

/* tb/bounded_ordered_list_check.sv */
// ---------------------------------------------------------------------------
// bounded_ordered_list_check
// Watches both stream channels of the ordered list, keeps its own copy of the
// list contents, works out the reply to every accepted command word and
// compares each reply word, field by field, with the oldest one still due.
// ---------------------------------------------------------------------------
module bounded_ordered_list_check
  import blo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // position[6:0], new_value[16:7], zero pad
  input  logic [3:0]  s_tuser,   // operation[2:0], new_kind[3]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // read_value[10:0], count[17:11], zero pad
  input  logic [1:0]  m_tuser,   // ok[0], read_kind[1]
  output int          pending,
  output int          failures
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [NV_W-1:0] VALUE_MASK = NV_W'((1 << VALUE_BITS) - 1);

  typedef struct packed {
    logic            ok;
    logic            read_kind;
    logic [RV_W-1:0] read_value;
    logic [CNT_W-1:0] count;
  } list_reply_t;

  // Shadow copy of the list
  logic            entry_kind  [CAPACITY];
  logic [RV_W-1:0] entry_value [CAPACITY];
  int              entry_count;

  list_reply_t replies_due[$];
  int          reply_index;

  initial failures = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] reply %0d: %s", $time, reply_index, msg);
    failures++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  task automatic empty_entry(input int idx);
    entry_kind[idx]  = 1'b0;
    entry_value[idx] = EMPTY_VALUE;
  endtask

  task automatic empty_list();
    for (int i = 0; i < CAPACITY; i++)
      empty_entry(i);
    entry_count = 0;
  endtask

  // Apply one command to the shadow list and work out its reply
  task automatic list_operation(input logic [OP_W-1:0] code_bits, input int pos,
                                input logic kind, input logic [NV_W-1:0] value,
                                output list_reply_t reply);
    op_t             code;
    logic [RV_W-1:0] stored;
    int              last;
    code   = op_t'(code_bits);
    stored = RV_W'(value & VALUE_MASK);
    reply.ok         = 1'b0;
    reply.read_kind  = 1'b0;
    reply.read_value = EMPTY_VALUE;
    case (code)
      OP_PEEK: begin
        if (pos < entry_count) begin
          reply.ok         = 1'b1;
          reply.read_kind  = entry_kind[pos];
          reply.read_value = entry_value[pos];
        end
      end
      OP_APPEND: begin
        if (entry_count < CAPACITY) begin
          entry_kind[entry_count]  = kind;
          entry_value[entry_count] = stored;
          entry_count++;
          reply.ok = 1'b1;
        end
      end
      OP_INSERT: begin
        // a full list drops its last entry to make room
        if (pos <= entry_count && pos < CAPACITY) begin
          last = (entry_count < CAPACITY) ? entry_count : CAPACITY - 1;
          for (int i = last; i > pos; i--) begin
            entry_kind[i]  = entry_kind[i-1];
            entry_value[i] = entry_value[i-1];
          end
          entry_kind[pos]  = kind;
          entry_value[pos] = stored;
          entry_count      = last + 1;
          reply.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos < entry_count) begin
          for (int i = pos; i < entry_count - 1; i++) begin
            entry_kind[i]  = entry_kind[i+1];
            entry_value[i] = entry_value[i+1];
          end
          empty_entry(entry_count - 1);
          entry_count--;
          reply.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        empty_list();
        reply.ok = 1'b1;
      end
      default: ;
    endcase
    reply.count = CNT_W'(entry_count);
  endtask

  // Check the reply word first: it always belongs to an earlier command word
  always @(posedge clk) begin : watch
    list_reply_t want;
    if (rst) begin
      empty_list();
      replies_due.delete();
      reply_index = 0;
      pending <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("reply word with no command outstanding");
        end else begin
          want = replies_due.pop_front();
          check_field("ok", m_tuser[0], want.ok);
          check_field("read_kind", m_tuser[1], want.read_kind);
          check_field("read_value", m_tdata[RV_W-1:0], want.read_value);
          check_field("count", m_tdata[RV_W +: CNT_W], want.count);
        end
        reply_index++;
      end
      if (s_tvalid && s_tready) begin
        list_operation(s_tuser[OP_W-1:0], int'(s_tdata[POS_W-1:0]), s_tuser[OP_W],
                       s_tdata[POS_W +: NV_W], want);
        replies_due.push_back(want);
      end
      pending <= replies_due.size();
    end
  end

endmodule

/* tb/bounded_ordered_list_test.sv */
// ---------------------------------------------------------------------------
// bounded_ordered_list_test
// Drives command words into the ordered list: a directed opening over the
// edge cases, then random runs that fill, churn and drain the list, with
// random gaps on the sender and random stalls on the receiver. The checker
// beside the block predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module bounded_ordered_list_test;
  timeunit 1ns;
  timeprecision 1ps;

  import blo_pkg::*;

  localparam int RANDOM_WORDS      = 1500;
  localparam int CALM_TAIL         = 200;
  localparam int CALM_FROM         = 600;
  localparam int CALM_TO           = 800;
  localparam int PHASE_WORDS       = 150;
  localparam int LONG_STALL_AT     = 400;
  localparam int LONG_STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES      = 8;
  localparam int CYCLE_LIMIT       = 500000;
  localparam int IN_PAD            = 24 - POS_W - NV_W;

  localparam logic [OP_W-1:0] OP_RESERVED_FIRST = OP_W'(OP_CLEAR) + 1'b1;
  localparam logic [OP_W-1:0] OP_RESERVED_LAST  = '1;
  localparam logic [NV_W-1:0] VALUE_MAX         = '1;
  localparam logic [POS_W-1:0] POS_MAX          = '1;

  typedef enum int {PHASE_GROW, PHASE_CHURN, PHASE_SHRINK} run_phase_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;
  logic [3:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;

  int pending;
  int failures;
  int words_sent = 0;
  int cycles     = 0;
  bit calm       = 1'b0;

  bounded_ordered_list dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  bounded_ordered_list_check checker_inst (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pending  (pending),
    .failures (failures)
  );

  always #5 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("bounded_ordered_list verification failed");
      $finish;
    end
  end

  // Offer one command word, hold it until taken, then maybe pause
  task automatic send_word(input logic [OP_W-1:0] code, input logic [POS_W-1:0] pos,
                           input logic kind, input logic [NV_W-1:0] value);
    s_tuser  <= {kind, code};
    s_tdata  <= {{IN_PAD{1'b0}}, value, pos};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    words_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // One random command, weighted by the phase of the run
  task automatic send_random(input run_phase_t phase);
    logic [OP_W-1:0]  code;
    logic [POS_W-1:0] pos;
    logic [NV_W-1:0]  value;
    int               roll;
    int               add_cut;
    int               ins_cut;
    int               peek_cut;
    add_cut  = (phase == PHASE_GROW) ? 45 : (phase == PHASE_CHURN) ? 25 : 10;
    ins_cut  = (phase == PHASE_GROW) ? 80 : (phase == PHASE_CHURN) ? 50 : 20;
    peek_cut = (phase == PHASE_GROW) ? 92 : (phase == PHASE_CHURN) ? 75 : 45;
    roll = $urandom_range(0, 99);
    if (roll < add_cut)
      code = OP_APPEND;
    else if (roll < ins_cut)
      code = OP_INSERT;
    else if (roll < peek_cut)
      code = OP_PEEK;
    else if (roll < 98)
      code = OP_REMOVE;
    else if ($urandom_range(0, 2) == 0)
      code = OP_CLEAR;
    else
      code = OP_RESERVED_FIRST + OP_W'($urandom_range(0, 2));

    // positions lean towards short lists, the tail and just past it
    roll = $urandom_range(0, 99);
    if (roll < 40)
      pos = POS_W'($urandom_range(0, 15));
    else if (roll < 85)
      pos = POS_W'($urandom_range(0, CAPACITY - 1));
    else if (roll < 95)
      pos = POS_W'($urandom_range(CAPACITY - 1, CAPACITY + 1));
    else
      pos = POS_W'($urandom_range(0, 2 ** POS_W - 1));

    roll = $urandom_range(0, 19);
    if (roll == 0)
      value = '0;
    else if (roll == 1)
      value = VALUE_MAX;
    else
      value = NV_W'($urandom_range(0, 2 ** NV_W - 1));

    send_word(code, pos, 1'($urandom_range(0, 1)), value);
  endtask

  // Receiver: random stalls, one long hold-off to fill the block
  initial begin : sink_side
    bit long_done;
    long_done = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!long_done && words_sent >= LONG_STALL_AT) begin
        m_tready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
        long_done = 1'b1;
        m_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : source_side
    run_phase_t phase;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty list: peek and remove out of range, insert past the end
    send_word(OP_PEEK, '0, 1'b0, '0);
    send_word(OP_REMOVE, '0, 1'b0, '0);
    send_word(OP_INSERT, 7'd1, 1'b1, VALUE_MAX);
    // Build a short list: insert at head, append, insert at the end, in the middle
    send_word(OP_INSERT, '0, 1'b1, VALUE_MAX);
    send_word(OP_APPEND, POS_MAX, 1'b0, '0);
    send_word(OP_INSERT, 7'd2, 1'b1, 10'h155);
    send_word(OP_INSERT, 7'd1, 1'b0, 10'h2AA);
    for (int i = 0; i <= 4; i++)
      send_word(OP_PEEK, POS_W'(i), 1'b0, '0);
    send_word(OP_PEEK, POS_MAX, 1'b1, VALUE_MAX);
    // Remove the tail, the head and out of range
    send_word(OP_REMOVE, 7'd3, 1'b0, '0);
    send_word(OP_REMOVE, '0, 1'b0, '0);
    send_word(OP_REMOVE, POS_MAX, 1'b1, VALUE_MAX);
    // Unused operation codes leave the list alone
    send_word(OP_RESERVED_FIRST, POS_MAX, 1'b1, VALUE_MAX);
    send_word(OP_RESERVED_LAST, '0, 1'b1, VALUE_MAX);
    send_word(OP_PEEK, 7'd1, 1'b0, '0);
    send_word(OP_CLEAR, POS_MAX, 1'b1, VALUE_MAX);
    send_word(OP_PEEK, '0, 1'b0, '0);
    send_word(OP_APPEND, '0, 1'b1, VALUE_MAX);

    // Random runs: grow, churn, shrink in turn; quiet window and quiet tail
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm <= (n >= CALM_FROM && n < CALM_TO) || (n >= RANDOM_WORDS - CALM_TAIL);
      phase = run_phase_t'((n / PHASE_WORDS) % 3);
      send_random(phase);
    end
    s_tvalid <= 1'b0;

    // Drain the outstanding replies
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("bounded_ordered_list verification clean");
    else
      $display("bounded_ordered_list verification failed");
    $finish;
  end

endmodule
